@@ hw/rtl/rau_pkg.sv @@
`default_nettype none

package rau_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_CMP = 3'd4;

    // Datapath widths.
    localparam int WORD_W  = 64;
    localparam int DEN_W   = 62;
    localparam int COUNT_W = 7;

    // Input item layout, lowest bit first.
    localparam int FUNC_LSB = 0;
    localparam int AN_LSB   = 3;
    localparam int AD_LSB   = 35;
    localparam int BN_LSB   = 66;
    localparam int BD_LSB   = 98;
    localparam int S_DATA_W = 136;

    // Result item layout, lowest bit first.
    localparam int RN_LSB   = 0;
    localparam int RD_LSB   = 64;
    localparam int LT_BIT   = 126;
    localparam int EQ_BIT   = 127;
    localparam int GT_BIT   = 128;
    localparam int ERR_BIT  = 129;
    localparam int M_DATA_W = 136;

endpackage

`default_nettype wire

@@ hw/rtl/rau_div.sv @@
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rau_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rau_pkg::WORD_W-1:0]  dividend,
    input  wire logic [rau_pkg::WORD_W-1:0]  divisor,
    output logic                             done,
    output logic [rau_pkg::WORD_W-1:0]       quotient
);

    logic [rau_pkg::WORD_W:0]    rem_reg, rem_next;
    logic [rau_pkg::WORD_W-1:0]  quo_reg, quo_next;
    logic [rau_pkg::WORD_W-1:0]  dvs_reg, dvs_next;
    logic [rau_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [rau_pkg::WORD_W:0]    shifted;

    // One shift and trial subtract per cycle.
    always_comb begin
        shifted   = {rem_reg[rau_pkg::WORD_W-1:0], quo_reg[rau_pkg::WORD_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[rau_pkg::WORD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next    = shifted - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end else begin
                rem_next = shifted;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rau_pkg::COUNT_W'(rau_pkg::WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // A finished division always follows a busy cycle.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without busy");

endmodule

`default_nettype wire

@@ hw/rtl/rational_arithmetic_unit.sv @@
`default_nettype none

// Channel   Direction  Payload
// s_*       in         func, a_numerator, a_denominator, b_numerator, b_denominator
// m_*       out        result_numerator, result_denominator, flags
//
// A request is taken in the idle state, then forms three products on the multiplier and
// combines them. Arithmetic results then run a binary GCD, one step per cycle, plus two
// divisions when the GCD is not 1. Compare, errors and unknown codes go straight from
// the combine step to the output.
// Reset is synchronous and active low; it clears the sequencer and output valid.
// A waiting result does not block the next request; a stalled result holds the
// sequencer in its final state until the output register frees.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // func, a_numerator, a_denominator, b_numerator, b_denominator, zero pad
    input  wire logic [rau_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_numerator, result_denominator, is_less, is_equal, is_greater,
    // divide_by_zero, zero pad
    output logic [rau_pkg::M_DATA_W-1:0]         m_tdata
);

    localparam int W  = OPERAND_WIDTH;
    localparam int WW = rau_pkg::WORD_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_COMB, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]              func_reg, func_next;
    logic signed [W:0]       an_reg, an_next, bn_reg, bn_next;
    logic signed [W:0]       ad_reg, ad_next, bd_reg, bd_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic signed [WW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [WW-1:0]           d_reg, d_next;
    logic [WW-1:0]           nmag_reg, nmag_next;
    logic                    neg_reg, neg_next;
    logic [WW-1:0]           gu_reg, gu_next, gv_reg, gv_next;
    logic [rau_pkg::COUNT_W-1:0] gk_reg, gk_next;
    logic                    lt_reg, lt_next, eq_reg, eq_next;
    logic                    gt_reg, gt_next, err_reg, err_next;
    logic                    m_valid_reg, m_valid_next;
    logic [rau_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic signed [W:0]       mul_a, mul_b, bn_abs;
    logic signed [2*W+1:0]   prod;
    logic signed [WW-1:0]    prod64, n_val;
    logic                    div_start, div_done;
    logic [WW-1:0]           div_dividend, div_divisor, div_q;
    logic                    bad_den;

    // Shared multiplier, one product per cycle.
    always_comb begin
        bn_abs = bn_reg[W] ? -bn_reg : bn_reg;
        unique case (cnt_reg)
            2'd0: begin
                mul_a = an_reg;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? bn_reg : bd_reg;
            end
            2'd1: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = (func_reg == rau_pkg::FUNC_DIV) ? bn_abs : bd_reg;
            end
        endcase
        prod   = mul_a * mul_b;
        prod64 = WW'(prod);
    end

    // Combined numerator for the arithmetic operations.
    always_comb begin
        unique case (func_reg)
            rau_pkg::FUNC_ADD: n_val = x_reg + y_reg;
            rau_pkg::FUNC_SUB: n_val = x_reg - y_reg;
            rau_pkg::FUNC_DIV: n_val = bn_reg[W] ? -x_reg : x_reg;
            default:           n_val = x_reg;
        endcase
        bad_den = (ad_reg == '0) || (bd_reg == '0);
    end

    assign div_divisor  = gv_reg << gk_reg;
    assign div_dividend = (state_reg == ST_GCD) ? nmag_reg : d_reg;

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        d_next       = d_reg;
        nmag_next    = nmag_reg;
        neg_next     = neg_reg;
        gu_next      = gu_reg;
        gv_next      = gv_reg;
        gk_next      = gk_reg;
        lt_next      = lt_reg;
        eq_next      = eq_reg;
        gt_next      = gt_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        s_tready     = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tdata[rau_pkg::FUNC_LSB +: 3];
                    an_next    = {s_tdata[rau_pkg::AN_LSB + W - 1],
                                  s_tdata[rau_pkg::AN_LSB +: W]};
                    ad_next    = {2'b00, s_tdata[rau_pkg::AD_LSB +: W - 1]};
                    bn_next    = {s_tdata[rau_pkg::BN_LSB + W - 1],
                                  s_tdata[rau_pkg::BN_LSB +: W]};
                    bd_next    = {2'b00, s_tdata[rau_pkg::BD_LSB +: W - 1]};
                    cnt_next   = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                unique case (cnt_reg)
                    2'd0:    x_next = prod64;
                    2'd1:    y_next = prod64;
                    default: d_next = prod64;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    state_next = ST_COMB;
                end
            end
            ST_COMB: begin
                // Sort out errors, compares and unknown codes first.
                lt_next   = 1'b0;
                eq_next   = 1'b0;
                gt_next   = 1'b0;
                err_next  = 1'b0;
                nmag_next = '0;
                neg_next  = 1'b0;
                d_next    = WW'(1);
                if (bad_den || (func_reg == rau_pkg::FUNC_DIV && bn_reg == '0)) begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end else if (func_reg == rau_pkg::FUNC_CMP) begin
                    lt_next    = x_reg < y_reg;
                    eq_next    = x_reg == y_reg;
                    gt_next    = x_reg > y_reg;
                    state_next = ST_OUT;
                end else if (func_reg > rau_pkg::FUNC_CMP) begin
                    state_next = ST_OUT;
                end else begin
                    nmag_next  = n_val[WW-1] ? WW'(-n_val) : WW'(n_val);
                    neg_next   = n_val[WW-1];
                    d_next     = d_reg;
                    gu_next    = n_val[WW-1] ? WW'(-n_val) : WW'(n_val);
                    gv_next    = d_reg;
                    gk_next    = '0;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                // Binary GCD, one step per cycle.
                if (gu_reg == '0) begin
                    if (gv_reg == WW'(1) && gk_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIVN;
                    end
                end else if (!gu_reg[0] && !gv_reg[0]) begin
                    gu_next = gu_reg >> 1;
                    gv_next = gv_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end else if (!gu_reg[0]) begin
                    gu_next = gu_reg >> 1;
                end else if (!gv_reg[0]) begin
                    gv_next = gv_reg >> 1;
                end else if (gu_reg >= gv_reg) begin
                    gu_next = (gu_reg - gv_reg) >> 1;
                end else begin
                    gv_next = (gv_reg - gu_reg) >> 1;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    nmag_next  = div_q;
                    div_start  = 1'b1;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    d_next     = div_q;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next = '0;
                    m_data_next[rau_pkg::RN_LSB +: WW] = neg_reg ? -nmag_reg : nmag_reg;
                    m_data_next[rau_pkg::RD_LSB +: rau_pkg::DEN_W] =
                        d_reg[rau_pkg::DEN_W-1:0];
                    m_data_next[rau_pkg::LT_BIT]  = lt_reg;
                    m_data_next[rau_pkg::EQ_BIT]  = eq_reg;
                    m_data_next[rau_pkg::GT_BIT]  = gt_reg;
                    m_data_next[rau_pkg::ERR_BIT] = err_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg   <= func_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        d_reg      <= d_next;
        nmag_reg   <= nmag_next;
        neg_reg    <= neg_next;
        gu_reg     <= gu_next;
        gv_reg     <= gv_next;
        gk_reg     <= gk_next;
        lt_reg     <= lt_next;
        eq_reg     <= eq_next;
        gt_reg     <= gt_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVN || state_reg == ST_DIVD))
        else $error("divider finished outside a divide state");

    // A delivered denominator is never zero.
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[rau_pkg::RD_LSB +: rau_pkg::DEN_W] != '0))
        else $error("zero result denominator");

    // At most one compare flag is set.
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0(m_data_reg[rau_pkg::GT_BIT:rau_pkg::LT_BIT]))
        else $error("several compare flags set");

    // An error result is zero with no compare flags.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[rau_pkg::ERR_BIT]) |->
        (m_data_reg[rau_pkg::RN_LSB +: WW] == '0 &&
         m_data_reg[rau_pkg::GT_BIT:rau_pkg::LT_BIT] == '0))
        else $error("error result not cleared");

endmodule

`default_nettype wire
